// ===== hdl/lrap_pkg.sv =====
package lrap_pkg;

   localparam int PIXELS  = 60;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int POS_W   = 22;
   localparam int RL_W    = 23;
   localparam int NUM_W   = 30;
   localparam int FULL    = PIXELS * 65536;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_FADE  = 2'd2;
   localparam logic [1:0] CMD_SHOW  = 2'd3;

   localparam logic CSR_FADE_START = 1'b0;
   localparam logic CSR_FADE_END   = 1'b1;

   typedef struct packed {
      logic load;
      logic clear;
      logic setup1;
      logic setup2;
      logic rd;
      logic dchk;
      logic dstep;
      logic m1;
      logic m2;
      logic m3;
      logic wr;
      logic show_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       equal_ends;
      logic       walk_done;
      logic       div_last;
      logic       show_last;
      logic       out_free;
   } ctl_sts_type;

   function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [8:0] f);
      logic [17:0] s;
      s = 18'(a) * (18'd256 - 18'(f)) + 18'(b) * 18'(f) + 18'd128;
      return s[15:8];
   endfunction

endpackage

// ===== hdl/lrap_ctrl.sv =====
module lrap_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lrap_pkg::ctl_sts_type sts,
   output lrap_pkg::ctl_cmd_type cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_DEC   = 13'b0000000000010,
      S_SET1  = 13'b0000000000100,
      S_SET2  = 13'b0000000001000,
      S_RD    = 13'b0000000010000,
      S_DCHK  = 13'b0000000100000,
      S_DIV   = 13'b0000001000000,
      S_M1    = 13'b0000010000000,
      S_M2    = 13'b0000100000000,
      S_M3    = 13'b0001000000000,
      S_BL    = 13'b0010000000000,
      S_SHRD  = 13'b0100000000000,
      S_SHOUT = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            unique case (sts.cmd)
               lrap_pkg::CMD_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               lrap_pkg::CMD_ADD,
               lrap_pkg::CMD_FADE: state_in = S_SET1;
               lrap_pkg::CMD_SHOW: state_in = S_SHRD;
               default:            state_in = S_IDLE;
            endcase
         end
         S_SET1: begin
            cmd.setup1 = 1'b1;
            state_in   = sts.equal_ends ? S_IDLE : S_SET2;
         end
         S_SET2: begin
            cmd.setup2 = 1'b1;
            state_in   = S_RD;
         end
         S_RD: begin
            if (sts.walk_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = (sts.cmd == lrap_pkg::CMD_FADE) ? S_DCHK : S_BL;
            end
         end
         S_DCHK: begin
            cmd.dchk = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.dstep = 1'b1;
            if (sts.div_last) state_in = S_M1;
         end
         S_M1: begin
            cmd.m1   = 1'b1;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.m2   = 1'b1;
            state_in = S_M3;
         end
         S_M3: begin
            cmd.m3   = 1'b1;
            state_in = S_BL;
         end
         S_BL: begin
            cmd.wr   = 1'b1;
            state_in = S_RD;
         end
         S_SHRD: begin
            cmd.rd   = 1'b1;
            state_in = S_SHOUT;
         end
         S_SHOUT: begin
            if (sts.out_free) begin
               cmd.show_out = 1'b1;
               state_in     = sts.show_last ? S_IDLE : S_SHRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lrap_dp.sv =====
module lrap_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  lrap_pkg::ctl_cmd_type cmd,
   output lrap_pkg::ctl_sts_type sts,
   input  logic [1:0]           req_cmd,
   input  logic [15:0]          req_start_pos,
   input  logic [15:0]          req_end_pos,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_pixel_index,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic                 rsp_last_pixel,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [8:0]           csr_wdata
);

   logic [23:0]                 mem [lrap_pkg::PIXELS];
   logic [lrap_pkg::PIXELS-1:0] valid_ff;

   logic [1:0]  cmd_ff;
   logic [15:0] spos_ff, epos_ff;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic [8:0]  fs_ff, fe_ff;

   logic [lrap_pkg::POS_W-1:0] sp_ff, ep_ff;
   logic [lrap_pkg::RL_W-1:0]  rl_ff;
   logic [lrap_pkg::IDX_W-1:0] first_ff, end_ff, last_ff, i_ff;
   logic [15:0]                sfrac_ff, egap_ff;
   logic [lrap_pkg::CNT_W-1:0] j_ff;

   logic [23:0] rd_ff;
   logic        rd_vld_ff;
   logic [8:0]  cov_ff;
   logic [lrap_pkg::NUM_W-1:0] rem_ff;
   logic [8:0]  q_ff;
   logic        sat_ff;
   logic [3:0]  k_ff;
   logic [8:0]  t8_ff, level_ff, f_ff;

   logic        rsp_valid_ff;
   logic [5:0]  o_idx_ff;
   logic [23:0] o_pix_ff;
   logic        o_last_ff;

   logic [8:0]  csr_v;
   assign csr_v = (csr_wdata > 9'd256) ? 9'd256 : csr_wdata;

   // setup arithmetic
   logic [lrap_pkg::POS_W-1:0] sp_in, ep_in;
   logic [lrap_pkg::RL_W-1:0]  rl_in, ceil_sum, gap_full;
   logic [6:0]                 ce;
   logic [lrap_pkg::IDX_W-1:0] end_in;
   assign sp_in    = lrap_pkg::POS_W'(spos_ff) * lrap_pkg::POS_W'(lrap_pkg::PIXELS);
   assign ep_in    = lrap_pkg::POS_W'(epos_ff) * lrap_pkg::POS_W'(lrap_pkg::PIXELS);
   assign rl_in    = (sp_ff < ep_ff) ? lrap_pkg::RL_W'(ep_ff - sp_ff)
                   : lrap_pkg::RL_W'(lrap_pkg::FULL) - lrap_pkg::RL_W'(sp_ff)
                     + lrap_pkg::RL_W'(ep_ff);
   assign ceil_sum = lrap_pkg::RL_W'(ep_ff) + lrap_pkg::RL_W'(17'h0FFFF);
   assign ce       = ceil_sum[22:16];
   assign gap_full = {ce, 16'h0000} - lrap_pkg::RL_W'(ep_ff);
   assign end_in   = (ce == 7'(lrap_pkg::PIXELS)) ? '0 : ce[lrap_pkg::IDX_W-1:0];

   // coverage of current pixel
   logic [16:0] cut, cov;
   logic [17:0] cov_r;
   assign cut   = ((i_ff == first_ff) ? 17'(sfrac_ff) : 17'd0)
                + ((i_ff == last_ff) ? 17'(egap_ff) : 17'd0);
   assign cov   = (cut >= 17'h10000) ? 17'd0 : 17'h10000 - cut;
   assign cov_r = 18'(cov) + 18'd128;

   // progress division
   logic [31:0] trial;
   logic [8:0]  p8;
   assign trial = 32'(rl_ff) << k_ff;
   assign p8    = (sat_ff || q_ff > 9'd256) ? 9'd256 : q_ff;

   logic [17:0] sq, lvl_sum, fsum;
   logic [8:0]  t8_in;
   assign sq      = 18'(p8) * 18'(p8) + 18'd128;
   assign t8_in   = 9'd256 - 9'(sq[17:8]);
   assign lvl_sum = 18'(fs_ff) * (18'd256 - 18'(t8_ff)) + 18'(fe_ff) * 18'(t8_ff) + 18'd128;
   assign fsum    = 18'(level_ff) * 18'(cov_ff) + 18'd128;

   // blend
   logic [23:0] pix;
   logic [8:0]  f_sel;
   logic [23:0] new_pix;
   logic [lrap_pkg::IDX_W-1:0] i_next;
   assign pix     = rd_vld_ff ? rd_ff : 24'h0;
   assign f_sel   = (cmd_ff == lrap_pkg::CMD_FADE) ? f_ff
                  : ((pix == 24'h0) ? cov_ff : 9'd128);
   assign new_pix = {lrap_pkg::blend8(pix[23:16], r_ff, f_sel),
                     lrap_pkg::blend8(pix[15:8], g_ff, f_sel),
                     lrap_pkg::blend8(pix[7:0], b_ff, f_sel)};
   assign i_next  = (i_ff == lrap_pkg::IDX_W'(lrap_pkg::PIXELS - 1)) ? '0 : i_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.rd) rd_ff <= mem[i_ff];
      if (cmd.wr) mem[i_ff] <= new_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fs_ff        <= 9'd256;
         fe_ff        <= 9'd0;
      end else begin
         if (cmd.clear) valid_ff <= '0;
         else if (cmd.wr) valid_ff[i_ff] <= 1'b1;
         if (cmd.show_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               lrap_pkg::CSR_FADE_START: fs_ff <= csr_v;
               lrap_pkg::CSR_FADE_END:   fe_ff <= csr_v;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         spos_ff <= req_start_pos;
         epos_ff <= req_end_pos;
         r_ff    <= req_red;
         g_ff    <= req_green;
         b_ff    <= req_blue;
         i_ff    <= '0;
      end
      if (cmd.setup1) begin
         sp_ff <= sp_in;
         ep_ff <= ep_in;
      end
      if (cmd.setup2) begin
         rl_ff    <= rl_in;
         first_ff <= sp_ff[21:16];
         sfrac_ff <= sp_ff[15:0];
         egap_ff  <= gap_full[15:0];
         end_ff   <= end_in;
         last_ff  <= (end_in == '0) ? lrap_pkg::IDX_W'(lrap_pkg::PIXELS - 1)
                                    : end_in - 1'b1;
         i_ff     <= sp_ff[21:16];
         j_ff     <= '0;
      end
      if (cmd.rd) begin
         rd_vld_ff <= valid_ff[i_ff];
         cov_ff    <= cov_r[16:8];
         rem_ff    <= {j_ff[5:0], 24'h0};
      end
      if (cmd.dchk) begin
         sat_ff <= ({2'b00, rem_ff} >= {rl_ff, 9'h000});
         q_ff   <= '0;
         k_ff   <= 4'd8;
      end
      if (cmd.dstep) begin
         if (32'(rem_ff) >= trial) begin
            rem_ff     <= rem_ff - trial[lrap_pkg::NUM_W-1:0];
            q_ff[k_ff] <= 1'b1;
         end
         k_ff <= k_ff - 1'b1;
      end
      if (cmd.m1) t8_ff <= t8_in;
      if (cmd.m2) level_ff <= lvl_sum[16:8];
      if (cmd.m3) f_ff <= fsum[16:8];
      if (cmd.wr) begin
         i_ff <= i_next;
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.show_out) begin
         o_idx_ff  <= i_ff;
         o_pix_ff  <= rd_vld_ff ? rd_ff : 24'h0;
         o_last_ff <= (i_ff == lrap_pkg::IDX_W'(lrap_pkg::PIXELS - 1));
         i_ff      <= i_next;
      end
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.equal_ends = (spos_ff == epos_ff);
      sts.walk_done  = (j_ff == lrap_pkg::CNT_W'(lrap_pkg::PIXELS)) || (i_ff == end_ff);
      sts.div_last   = (k_ff == 4'd0);
      sts.show_last  = (i_ff == lrap_pkg::IDX_W'(lrap_pkg::PIXELS - 1));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = o_idx_ff;
   assign rsp_red_out     = o_pix_ff[23:16];
   assign rsp_green_out   = o_pix_ff[15:8];
   assign rsp_blue_out    = o_pix_ff[7:0];
   assign rsp_last_pixel  = o_last_ff;

endmodule

// ===== hdl/led_ring_antialiased_arc_painter.sv =====
// channel   direction  ports
// req       in         req_valid/req_ready, cmd, start_pos, end_pos, red, green, blue
// rsp       out        rsp_valid/rsp_ready, pixel_index, red/green/blue_out, last_pixel
// csr       in         csr_we, csr_index, csr_wdata (write only)
//
// one item at a time; add sets up, then reads and blends each pixel walked (none for equal ends)
// fade also runs the 9-step bit-serial progress divider for each pixel walked
// show reads each pixel from the frame buffer, then puts it in the output register
// reset blacks the whole buffer at once through per-pixel valid bits
// a stalled rsp holds the show walk; the next item is taken while the last pixel waits
module led_ring_antialiased_arc_painter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_start_pos,
   input  logic [15:0] req_end_pos,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_pixel_index,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_last_pixel,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   lrap_pkg::ctl_cmd_type cmd;
   lrap_pkg::ctl_sts_type sts;

   lrap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrap_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_start_pos   (req_start_pos),
      .req_end_pos     (req_end_pos),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_index < 6'(lrap_pkg::PIXELS)))
      else $error("pixel index beyond ring");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |-> (rsp_pixel_index == 6'(lrap_pkg::PIXELS - 1)))
      else $error("last pixel flag on wrong index");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while previous item in progress");

endmodule
